// ===== sv/mudns_pkg.sv =====
// ----------------------------------------------------------------------------
// mudns_pkg
// Shared constants and types for the up/down MIDI note sequencer.
// ----------------------------------------------------------------------------
package mudns_pkg;

    localparam int QuietSamples = 12;
    localparam int HIST_BITS    = QuietSamples + 1;

    localparam logic [HIST_BITS-1:0] HIST_MATCH = HIST_BITS'(1) << QuietSamples;

    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

    localparam logic [6:0] LOW_NOTE_RST  = 7'h3C;
    localparam logic [6:0] HIGH_NOTE_RST = 7'h47;
    localparam logic [6:0] VELOCITY_RST  = 7'h64;
    localparam logic [3:0] CHANNEL_RST   = 4'h0;
    localparam logic [6:0] NOTE_RST      = 7'h3C;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_NOTE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_NOTE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VELOCITY  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL   = 2'd3;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

endpackage

// ===== sv/midi_updown_note_sequencer.sv =====
// ----------------------------------------------------------------------------
// midi_updown_note_sequencer
// Debounced start/stop MIDI sequencer sweeping a note up and down.
// ----------------------------------------------------------------------------
// Each request is one loop tick and is processed in the cycle it is accepted.
// A tick yields either nothing or one three-byte MIDI message (status, note,
// velocity), which is held in a message register and sent one byte per cycle
// while m_tready is high, with tlast on the third byte. The output port sets
// the rate: no tick is accepted while a message still has bytes pending,
// except that a new tick is accepted in the cycle the last byte of the
// previous message leaves. Configuration is to be written through the plain
// write port only while idle; the block itself does not enforce this.
module midi_updown_note_sequencer
    import mudns_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Bit 0 sample_strobe, bit 1 switch_level, bit 2 tempo_phase, rest zero.
    input  logic [7:0]            s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Bits 7:0 midi_byte.
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);

    logic [6:0]           low_note_reg;
    logic [6:0]           high_note_reg;
    logic [6:0]           velocity_reg;
    logic [3:0]           channel_reg;

    logic [HIST_BITS-1:0] hist_reg, hist_next;
    logic                 running_reg, running_next;
    dir_t                 dir_reg, dir_next;
    logic [6:0]           note_reg, note_next;
    logic                 sounding_reg, sounding_next;

    logic [23:0]          msg_reg, msg_next;
    logic [1:0]           cnt_reg, cnt_next;

    logic                 in_acc;
    logic                 out_acc;
    logic                 emit;
    logic [23:0]          msg_new;
    logic                 strobe;
    logic                 level;
    logic                 phase;

    assign strobe = s_tdata[0];
    assign level  = s_tdata[1];
    assign phase  = s_tdata[2];

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = msg_reg[7:0];
    assign m_tlast  = (cnt_reg == 2'd1);
    assign out_acc  = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_note_reg  <= LOW_NOTE_RST;
            high_note_reg <= HIGH_NOTE_RST;
            velocity_reg  <= VELOCITY_RST;
            channel_reg   <= CHANNEL_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_LOW_NOTE:  low_note_reg  <= cfg_wdata;
                CFG_HIGH_NOTE: high_note_reg <= cfg_wdata;
                CFG_VELOCITY:  velocity_reg  <= cfg_wdata;
                CFG_CHANNEL:   channel_reg   <= cfg_wdata[3:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        hist_next     = hist_reg;
        running_next  = running_reg;
        dir_next      = dir_reg;
        note_next     = note_reg;
        sounding_next = sounding_reg;
        emit          = 1'b0;
        msg_new       = '0;

        if (in_acc) begin
            if (strobe) begin
                hist_next = {hist_reg[HIST_BITS-2:0], level};
                if (hist_next == HIST_MATCH) begin
                    running_next = !running_reg;
                end
            end

            if (running_next) begin
                case (dir_reg)
                    DIR_IDLE: begin
                        dir_next = DIR_UP;
                    end
                    DIR_UP, DIR_DOWN: begin
                        if (!phase && !sounding_reg) begin
                            emit          = 1'b1;
                            sounding_next = 1'b1;
                            msg_new = {1'b0, velocity_reg, 1'b0, note_reg,
                                       STATUS_NOTE_ON, channel_reg};
                        end else if (phase && sounding_reg) begin
                            emit          = 1'b1;
                            sounding_next = 1'b0;
                            msg_new = {8'h00, 1'b0, note_reg,
                                       STATUS_NOTE_OFF, channel_reg};
                            if (dir_reg == DIR_UP) begin
                                if (note_reg >= high_note_reg) begin
                                    dir_next = DIR_DOWN;
                                end else begin
                                    note_next = note_reg + 7'd1;
                                end
                            end else begin
                                if (note_reg <= low_note_reg) begin
                                    dir_next = DIR_UP;
                                end else begin
                                    note_next = note_reg - 7'd1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        msg_next = msg_reg;
        cnt_next = cnt_reg;
        if (out_acc) begin
            msg_next = {8'h00, msg_reg[23:8]};
            cnt_next = cnt_reg - 2'd1;
        end
        if (emit) begin
            msg_next = msg_new;
            cnt_next = 2'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg     <= '0;
            running_reg  <= 1'b0;
            dir_reg      <= DIR_IDLE;
            note_reg     <= NOTE_RST;
            sounding_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end else begin
            hist_reg     <= hist_next;
            running_reg  <= running_next;
            dir_reg      <= dir_next;
            note_reg     <= note_next;
            sounding_reg <= sounding_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        msg_reg <= msg_next;
    end

    // A new tick is never taken while two or more bytes are still pending.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |-> (cnt_reg == 2'd0 || cnt_reg == 2'd1))
        else $error("tick accepted while a message is still pending");

    // Every message toggles the sounding flag.
    a_emit_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (sounding_reg != $past(sounding_reg)))
        else $error("message sent without toggling the sounding flag");

    // The note only moves when a tick is accepted.
    a_note_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_acc |=> $stable(note_reg))
        else $error("note changed without a tick");

    // A full message is only ever loaded once the sweep has started.
    a_dir_started: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd3) |-> (dir_reg != DIR_IDLE))
        else $error("message pending before the sweep started");

endmodule

// ===== tb/tb_midi_updown_note_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_midi_updown_note_sequencer
// Self-checking testbench for the up/down MIDI note sequencer.
// ----------------------------------------------------------------------------
// Loop ticks are sent as stream requests in bursts with random gaps, and the
// MIDI byte stream is drained by a receiver that stalls in changing patterns.
// A short table of ticks covers reset values, the debounced start and the
// first Note On and Note Off messages. Random phases follow, each under its own
// register setting: press sequences with random content, running ticks with
// alternating tempo phases, broken presses and noise. Every byte is compared
// with the table entry or the output of an independent model of the sequencer.
// ----------------------------------------------------------------------------
module tb_midi_updown_note_sequencer
    import mudns_pkg::*;
;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] ON_RST  = {STATUS_NOTE_ON, CHANNEL_RST};
    localparam logic [7:0] OFF_RST = {STATUS_NOTE_OFF, CHANNEL_RST};
    localparam logic [7:0] KEY_RST = {1'b0, NOTE_RST};
    localparam logic [7:0] VEL_RST = {1'b0, VELOCITY_RST};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } midi_byte_t;

    typedef struct packed {
        logic       strobe;
        logic       level;
        logic       phase;
        logic       typed;
        logic       has_msg;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } tick_row_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_EVERY_THIRD
    } ready_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    midi_updown_note_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    midi_byte_t      midi_q[$];
    midi_byte_t      oldest;
    tick_row_t       tick_rows [22];

    logic [HIST_BITS-1:0] hist_m;
    logic                 run_m;
    dir_t                 dir_m;
    logic [6:0]           note_m;
    logic                 sounding_m;
    logic [6:0]           lo_m;
    logic [6:0]           hi_m;
    logic [6:0]           vel_m;
    logic [3:0]           ch_m;
    logic [6:0]           k_note;

    int          errors;
    int          cycles;
    int          burst_left;
    int          live_ticks;
    ready_mode_t ready_mode;
    int          ready_span;
    int          ready_count;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("error at cycle %0d: %s", cycles, msg);
        end
    endfunction

    function automatic void push_message(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2);
        midi_q.push_back('{b0, 1'b0});
        midi_q.push_back('{b1, 1'b0});
        midi_q.push_back('{b2, 1'b1});
    endfunction

    function automatic void step_sequencer(input logic [2:0] f, input bit record);
        if (f[0]) begin
            hist_m = {hist_m[HIST_BITS-2:0], f[1]};
            if (hist_m == HIST_MATCH) begin
                run_m = ~run_m;
            end
        end
        if (!run_m) begin
            return;
        end
        if (dir_m == DIR_IDLE) begin
            dir_m = DIR_UP;
            return;
        end
        if (!f[2] && !sounding_m) begin
            if (record) begin
                push_message({STATUS_NOTE_ON, ch_m}, {1'b0, note_m}, {1'b0, vel_m});
            end
            sounding_m = 1'b1;
        end else if (f[2] && sounding_m) begin
            if (record) begin
                push_message({STATUS_NOTE_OFF, ch_m}, {1'b0, note_m}, 8'h00);
            end
            sounding_m = 1'b0;
            if (dir_m == DIR_UP) begin
                if (note_m >= hi_m) begin
                    dir_m = DIR_DOWN;
                end else begin
                    note_m = note_m + 7'd1;
                end
            end else if (note_m <= lo_m) begin
                dir_m = DIR_UP;
            end else begin
                note_m = note_m - 7'd1;
            end
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the request.
    task automatic send_tick(input logic [2:0] f, input bit record = 1'b1);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, f};
        do @(posedge aclk); while (!s_tready);
        step_sequencer(f, record);
        if (f[0] || run_m) begin
            live_ticks++;
        end
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (midi_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_LOW_NOTE:  lo_m  = val;
            CFG_HIGH_NOTE: hi_m  = val;
            CFG_VELOCITY:  vel_m = val;
            default:       ch_m  = val[3:0];
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [6:0] lo, input logic [6:0] hi,
                                 input logic [6:0] vel, input logic [6:0] ch);
        write_reg(CFG_LOW_NOTE, lo);
        write_reg(CFG_HIGH_NOTE, hi);
        write_reg(CFG_VELOCITY, vel);
        write_reg(CFG_CHANNEL, ch);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int target);
        int   stop_at;
        int   seg;
        logic p;
        stop_at = live_ticks + target;
        p = 1'b0;
        while (live_ticks < stop_at) begin
            seg = $urandom_range(0, 9);
            if (!run_m && seg > 3 && $urandom_range(0, 9) < 7) begin
                seg = 2;
            end
            case (seg)
                0: begin
                    repeat ($urandom_range(1, 4)) send_tick(3'($urandom_range(0, 7)));
                end
                1: begin
                    send_tick({1'($urandom_range(0, 1)), 2'b11});
                    repeat ($urandom_range(1, QuietSamples - 1)) begin
                        send_tick({1'($urandom_range(0, 1)), 2'b01});
                    end
                    send_tick({1'($urandom_range(0, 1)), 2'b11});
                end
                2: begin
                    send_tick({1'($urandom_range(0, 1)), 2'b11});
                    repeat (QuietSamples) begin
                        repeat ($urandom_range(0, 2)) begin
                            p = ~p;
                            send_tick({p, 2'b00});
                        end
                        send_tick({1'($urandom_range(0, 1)), 2'b01});
                    end
                end
                default: begin
                    repeat ($urandom_range(4, 16)) begin
                        p = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : ~p;
                        send_tick({p, 1'b0, 1'($urandom_range(0, 5) == 0)});
                    end
                end
            endcase
        end
    endtask

    always @(negedge aclk) begin
        if (ready_span == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_span = $urandom_range(20, 80);
        end
        ready_span--;
        ready_count++;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            READY_RARELY: m_tready <= ($urandom_range(0, 9) < 4);
            default:      m_tready <= (ready_count % 3 == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("midi_updown_note_sequencer: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (midi_q.size() == 0) begin
                flag_error($sformatf("unexpected byte %h last %b", m_tdata, m_tlast));
            end else begin
                oldest = midi_q.pop_front();
                if (m_tdata !== oldest.data || m_tlast !== oldest.last) begin
                    flag_error($sformatf("expected byte %h last %b, got byte %h last %b",
                                         oldest.data, oldest.last, m_tdata, m_tlast));
                end
            end
        end
    end

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = CFG_LOW_NOTE;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        errors      = 0;
        cycles      = 0;
        burst_left  = 0;
        live_ticks  = 0;
        ready_mode  = READY_ALWAYS;
        ready_span  = 0;
        ready_count = 0;
        hist_m      = '0;
        run_m       = 1'b0;
        dir_m       = DIR_IDLE;
        note_m      = NOTE_RST;
        sounding_m  = 1'b0;
        lo_m        = LOW_NOTE_RST;
        hi_m        = HIGH_NOTE_RST;
        vel_m       = VELOCITY_RST;
        ch_m        = CHANNEL_RST;
        k_note      = '0;

        // The twelve quiet samples after the high one start the sequencer.
        tick_rows = '{
            '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, ON_RST, KEY_RST, VEL_RST},
            '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, OFF_RST, KEY_RST, 8'h00},
            '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
            '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00}
        };

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (tick_rows[i]) begin
            if (tick_rows[i].typed && tick_rows[i].has_msg) begin
                push_message(tick_rows[i].b0, tick_rows[i].b1, tick_rows[i].b2);
            end
            send_tick({tick_rows[i].phase, tick_rows[i].level, tick_rows[i].strobe},
                      !tick_rows[i].typed);
        end
        wait_idle();

        for (int ph = 1; ph <= 7; ph++) begin
            case (ph)
                1: apply_setting(7'd0, 7'd127, 7'd127, 7'h7F);
                2: apply_setting(7'd62, 7'd64, 7'd0, 7'h00);
                3: apply_setting(7'd127, 7'd127, 7'($urandom), 7'($urandom));
                4: apply_setting(7'd0, 7'd0, 7'($urandom), 7'($urandom));
                5: apply_setting(7'd70, 7'd50, 7'($urandom), 7'($urandom));
                6: apply_setting(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
                default: begin
                    k_note = 7'($urandom_range(40, 80));
                    apply_setting(k_note, k_note, 7'($urandom), 7'($urandom));
                end
            endcase
            run_phase(40);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0 && midi_q.size() == 0) begin
            $display("midi_updown_note_sequencer: match");
        end else begin
            $display("midi_updown_note_sequencer: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mudns_pkg.sv
sv/midi_updown_note_sequencer.sv
tb/tb_midi_updown_note_sequencer.sv
